### hw/rtl/brbs_pkg.sv
// Shared constants, types and count helpers for the run-boundary search unit.
// No dependencies; imported by the top level.
`default_nettype none

package brbs_pkg;

   localparam int WORD_BITS  = 32;
   localparam int MAX_BITS   = 1048576;
   localparam int WORD_COUNT = MAX_BITS / WORD_BITS;
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int WADDR_W    = $clog2(WORD_COUNT);
   localparam int CNT_W      = OFF_W + 1;

   // Fixed field widths of the transaction ports
   localparam int ACT_W       = 2;
   localparam int IDX_W       = 15;
   localparam int DATA_W      = 32;
   localparam int POS_W       = 21;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [ACT_W-1:0]     action_type;

   localparam action_type ACT_LOAD  = 2'd0;
   localparam action_type ACT_LEFT  = 2'd1;
   localparam action_type ACT_RIGHT = 2'd2;

   // Number of consecutive ones starting at bit 0
   function automatic cnt_type count_trailing_ones(input word_type v);
      cnt_type cnt;
      cnt = cnt_type'(WORD_BITS);
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (!v[k]) begin
            cnt = cnt_type'(k);
         end
      end
      return cnt;
   endfunction

   // Number of consecutive ones starting at the msb
   function automatic cnt_type count_leading_ones(input word_type v);
      cnt_type cnt;
      cnt = cnt_type'(WORD_BITS);
      for (int k = 0; k < WORD_BITS; k++) begin
         if (!v[k]) begin
            cnt = cnt_type'(WORD_BITS - 1 - k);
         end
      end
      return cnt;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/brbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module brbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/bit_run_boundary_search_unit.sv
// Top level of the run-boundary search unit: word store, scan sequencer, CSR.
// Depends on brbs_pkg and brbs_ram.
`default_nettype none

// Channel    | Ports                                   | Handshake
// -----------+-----------------------------------------+---------------------------
// request    | start, busy, req_*                      | taken when start && !busy
// response   | rsp_valid, rsp_new_position             | one-cycle strobe, no stall
// csr        | psel, penable, pwrite, paddr, pwdata,   | APB write on access phase,
//            | prdata, pready                          | pready tied high
//
// A load transaction returns nothing. A query whose answer is known from its
// start position alone (left at zero or beyond the store, right at or past
// the length or beyond the store) is answered without a scan. Any other query
// reads the word store once per cycle through its one read port; one shared
// encode/add/compare unit consumes each word, so busy stays high until the
// query's last word has been consumed, and its strobe is registered on the
// edge that returns the sequencer to idle.
// Reset is synchronous and clears control state and vector_length; the word
// store has no reset and must be loaded before it is searched.
// The response side cannot stall; a new transaction is taken in the cycle the
// strobe is shown.

module bit_run_boundary_search_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic [brbs_pkg::ACT_W-1:0]      req_action,
   input  wire logic [brbs_pkg::IDX_W-1:0]      req_word_index,
   input  wire logic [brbs_pkg::DATA_W-1:0]     req_word_data,
   input  wire logic [brbs_pkg::POS_W-1:0]      req_position,
   // response
   output      logic                            rsp_valid,
   output      logic [brbs_pkg::POS_W-1:0]      rsp_new_position,
   // csr
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [brbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [brbs_pkg::CSR_DATA_W-1:0] pwdata,
   output      logic [brbs_pkg::CSR_DATA_W-1:0] prdata,
   output      logic                            pready
);

   import brbs_pkg::*;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type            state_ff, state_in;
   logic                 dir_left_ff, dir_left_in;
   logic [WADDR_W-1:0]   word_ff, word_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pos_type              rsp_pos_ff, rsp_pos_in;
   pos_type              len_ff;

   logic                 accept;
   logic                 ram_wr_en;
   logic [WADDR_W-1:0]   ram_rd_addr;
   word_type             ram_rd_data;

   // Scan datapath signals
   pos_type              pos_m1;
   pos_type              cur_pos;
   pos_type              word_end;
   pos_type              hit_pos;
   word_type             aligned;
   cnt_type              run_cnt;
   cnt_type              run_lim;

   // ------------------------------------------------------------------
   // CSR: single register at index 0; a write anywhere in the port's range
   // lands in it.
   // ------------------------------------------------------------------
   assign pready = 1'b1;
   assign prdata = CSR_DATA_W'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         len_ff <= pwdata[POS_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Word store
   // ------------------------------------------------------------------
   assign accept    = start && !busy;
   assign ram_wr_en = accept && (req_action == ACT_LOAD) &&
                      ({1'b0, req_word_index} < (IDX_W + 1)'(WORD_COUNT));

   brbs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_words (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_word_index[WADDR_W-1:0]),
      .wr_data (req_word_data[WORD_BITS-1:0]),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Sequencer and shared scan unit
   // ------------------------------------------------------------------
   assign pos_m1   = req_position - pos_type'(1);
   assign cur_pos  = pos_type'({word_ff, off_ff});
   assign word_end = pos_type'({word_ff, {OFF_W{1'b0}}}) + pos_type'(WORD_BITS);

   // Left scans walk toward the msb of the word (the lsb side after the shift),
   // right scans toward the lsb of the word (the msb side after the shift).
   always_comb begin
      if (dir_left_ff) begin
         aligned = ram_rd_data >> (~off_ff);
         run_cnt = count_trailing_ones(aligned);
         run_lim = cnt_type'(off_ff) + cnt_type'(1);
         hit_pos = cur_pos + pos_type'(1) - pos_type'(run_cnt);
      end else begin
         aligned = ram_rd_data << off_ff;
         run_cnt = count_leading_ones(aligned);
         run_lim = cnt_type'(WORD_BITS) - cnt_type'(off_ff);
         hit_pos = cur_pos + pos_type'(run_cnt);
      end
   end

   always_comb begin
      state_in     = state_ff;
      dir_left_in  = dir_left_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      rsp_valid_in = 1'b0;
      rsp_pos_in   = rsp_pos_ff;
      ram_rd_addr  = dir_left_ff ? word_ff - WADDR_W'(1) : word_ff + WADDR_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = req_position[OFF_W +: WADDR_W];
            if (accept) begin
               unique case (req_action)
                  ACT_LEFT: begin
                     ram_rd_addr = pos_m1[OFF_W +: WADDR_W];
                     dir_left_in = 1'b1;
                     word_in     = pos_m1[OFF_W +: WADDR_W];
                     off_in      = pos_m1[OFF_W-1:0];
                     if (req_position == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = '0;
                     end else if (req_position > pos_type'(MAX_BITS)) begin
                        // preceding bit lies past the store: reads clear
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = req_position;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_RIGHT: begin
                     dir_left_in = 1'b0;
                     word_in     = req_position[OFF_W +: WADDR_W];
                     off_in      = req_position[OFF_W-1:0];
                     if (req_position >= len_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = len_ff;
                     end else if (req_position >= pos_type'(MAX_BITS)) begin
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = req_position;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     // load, or unused code: nothing returned
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (run_cnt < run_lim) begin
               // clear bit found inside this word
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (dir_left_ff) begin
                  rsp_pos_in = hit_pos;
               end else begin
                  rsp_pos_in = (hit_pos < len_ff) ? hit_pos : len_ff;
               end
            end else if (dir_left_ff) begin
               if (word_ff == '0) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_pos_in   = '0;
               end else begin
                  word_in = word_ff - WADDR_W'(1);
                  off_in  = '1;
               end
            end else begin
               if ((word_end >= len_ff) || (word_ff == '1)) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_pos_in   = (word_end < len_ff) ? word_end : len_ff;
               end else begin
                  word_in = word_ff + WADDR_W'(1);
                  off_in  = '0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dir_left_ff <= dir_left_in;
      word_ff     <= word_in;
      off_ff      <= off_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_position = rsp_pos_ff;

endmodule

`default_nettype wire
